// ===== hdl/fat_chain_block_allocator_top_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Needs clk and rst in scope at the point of use.
`ifndef FAT_CHAIN_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define FAT_CHAIN_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define FCBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define FCBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/fcba_pkg.sv =====
// Shared types and constants for the FAT chain block allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fcba_pkg;

  localparam int FIELD_W = 12;
  localparam logic [FIELD_W-1:0] FIELD_MAX = 12'hFFF;
  // Reset value of the usable block limit, in blocks
  localparam logic [FIELD_W-1:0] LIMIT_RESET = 12'd1952;

  // Command codes
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_NEXT  = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_OUT
  } fcba_state_t;

  typedef struct packed {
    logic               status;
    logic [FIELD_W-1:0] result_block;
    logic [FIELD_W-1:0] used_blocks;
  } fcba_result_t;

endpackage

`default_nettype wire

// ===== hdl/fcba_table.sv =====
// Link table memory: one write port, one read port with registered data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module fcba_table #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [AW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [AW-1:0] rd_data
);

  logic [AW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered; data appears in the next cycle
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/fcba_alu.sv =====
// Shared add/subtract unit used for the count and the chain walk.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps
`default_nettype none

module fcba_alu #(
  parameter int W = 17
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic         sub,
  output logic      [W-1:0] sum,
  output logic              msb   // carry on add, borrow on subtract
);

  logic [W:0] ext;

  // one W-bit adder, b inverted for subtract
  always_comb begin
    if (sub) begin
      ext = {1'b0, a} - {1'b0, b};
    end else begin
      ext = {1'b0, a} + {1'b0, b};
    end
    sum = ext[W-1:0];
    msb = ext[W];
  end

endmodule

`default_nettype wire

// ===== hdl/fcba_seq.sv =====
// Sequencer: clearing pass, command decode, chain walk, head and count.
// Depends on fcba_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "fat_chain_block_allocator_top_macros.svh"

module fcba_seq
  import fcba_pkg::*;
#(
  parameter int NUM_BLOCKS       = 4096,
  parameter int FIRST_DATA_BLOCK = 4,
  localparam int AW = $clog2(NUM_BLOCKS),
  localparam int CW = $clog2(NUM_BLOCKS + 2),
  localparam int W  = (CW > FIELD_W) ? CW : FIELD_W
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // command side
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_cmd,
  input  wire logic [FIELD_W-1:0] in_blk,
  // limit register
  input  wire logic               cfg_wr_en,
  input  wire logic [FIELD_W-1:0] cfg_wr_data,
  // result side
  output logic                    res_valid,
  input  wire logic               res_ready,
  output fcba_result_t            res,
  // link table
  output logic                    tbl_wr_en,
  output logic      [AW-1:0]      tbl_wr_addr,
  output logic      [AW-1:0]      tbl_wr_data,
  output logic      [AW-1:0]      tbl_rd_addr,
  input  wire logic [AW-1:0]      tbl_rd_data,
  // shared adder
  output logic      [W-1:0]       alu_a,
  output logic      [W-1:0]       alu_b,
  output logic                    alu_sub,
  input  wire logic [W-1:0]       alu_sum,
  input  wire logic               alu_msb
);

  localparam logic [W-1:0]  NB_W    = W'(NUM_BLOCKS);
  localparam logic [W-1:0]  FIRST_W = W'(FIRST_DATA_BLOCK);
  localparam logic [AW-1:0] LAST_A  = AW'(NUM_BLOCKS - 1);
  localparam logic [W-1:0]  ONE_W   = W'(1);

  fcba_state_t state, state_next;

  logic [AW-1:0]      init_addr;
  logic [AW-1:0]      init_val;
  logic [AW-1:0]      free_head;
  logic [FIELD_W-1:0] used_count;
  logic [FIELD_W-1:0] limit;
  logic [1:0]         cmd;
  logic [FIELD_W-1:0] blk;
  logic [AW-1:0]      walk;
  logic [W-1:0]       walk_n;
  logic               res_status;
  logic [FIELD_W-1:0] res_block;

  logic link_zero;
  logic n_over;
  logic in_range;
  logic alloc_ok;

  assign link_zero = (tbl_rd_data == '0);
  assign n_over    = (walk_n > NB_W);
  assign in_range  = (W'(in_blk) < NB_W);
  assign alloc_ok  = !link_zero && !(used_count > limit);

  // reset contents of one table entry for the clearing pass
  always_comb begin
    if ((W'(init_addr) < FIRST_W) || (init_addr == LAST_A)) begin
      init_val = '0;
    end else begin
      init_val = AW'(init_addr + AW'(1));
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshakes
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (init_addr == LAST_A) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          priority if (in_cmd == CMD_ALLOC) begin
            state_next = ST_READ;
          end else if ((in_cmd == CMD_FREE || in_cmd == CMD_NEXT) && in_range) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_READ: state_next = ST_EVAL;
      ST_EVAL: begin
        if (cmd == CMD_FREE && !link_zero && !n_over) begin
          state_next = ST_EVAL;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_OUT);
  assign res       = '{status: res_status, result_block: res_block, used_blocks: used_count};

  // adder operands: walk step, free count drop, or allocation count bump
  always_comb begin
    alu_a   = W'(used_count);
    alu_b   = ONE_W;
    alu_sub = 1'b0;
    if (state == ST_EVAL && cmd == CMD_FREE) begin
      if (!link_zero) begin
        alu_a = walk_n;
      end else begin
        alu_b   = walk_n;
        alu_sub = 1'b1;
      end
    end
  end

  // table ports; in EVAL the read follows the link just fetched
  always_comb begin
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = walk;
    tbl_wr_data = '0;
    tbl_rd_addr = (state == ST_EVAL) ? tbl_rd_data : walk;
    if (state == ST_INIT) begin
      tbl_wr_en   = 1'b1;
      tbl_wr_addr = init_addr;
      tbl_wr_data = init_val;
    end else if (state == ST_EVAL) begin
      if (cmd == CMD_ALLOC && alloc_ok) begin
        tbl_wr_en = 1'b1;
      end else if (cmd == CMD_FREE && link_zero) begin
        tbl_wr_en   = 1'b1;
        tbl_wr_data = free_head;
      end
    end
  end

  // limit register, writable at any time
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit <= cfg_wr_data;
    end
  end

  // control state: sweep address, free head, used count
  always_ff @(posedge clk) begin
    if (rst) begin
      init_addr  <= '0;
      free_head  <= AW'(FIRST_DATA_BLOCK);
      used_count <= FIELD_W'(1);
    end else begin
      if (state == ST_INIT) begin
        init_addr <= AW'(init_addr + AW'(1));
      end
      if (state == ST_EVAL) begin
        if (cmd == CMD_ALLOC && alloc_ok) begin
          free_head <= tbl_rd_data;
          if (used_count != FIELD_MAX) begin
            used_count <= alu_sum[FIELD_W-1:0];
          end
        end else if (cmd == CMD_FREE && link_zero) begin
          free_head  <= AW'(blk);
          used_count <= alu_msb ? '0 : alu_sum[FIELD_W-1:0];
        end
      end
    end
  end

  // beat payload and walk registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      cmd        <= in_cmd;
      blk        <= in_blk;
      walk       <= (in_cmd == CMD_ALLOC) ? free_head : AW'(in_blk);
      walk_n     <= ONE_W;
      res_status <= 1'b0;
      res_block  <= '0;
    end else if (state == ST_EVAL) begin
      unique case (cmd)
        CMD_ALLOC: begin
          if (alloc_ok) begin
            res_block <= FIELD_W'(walk);
          end else begin
            res_status <= 1'b1;
          end
        end
        CMD_FREE: begin
          if (!link_zero && !n_over) begin
            walk   <= tbl_rd_data;
            walk_n <= alu_sum;
          end
        end
        CMD_NEXT: res_block <= FIELD_W'(tbl_rd_data);
        default: res_block <= '0;
      endcase
    end
  end

  `FCBA_ASSERT_NOW(a_tbl_wr_state, tbl_wr_en, (state == ST_INIT) || (state == ST_EVAL), "table written outside sweep or evaluation")
  `FCBA_ASSERT_NOW(a_walk_bound, state == ST_EVAL, walk_n <= NB_W + ONE_W, "chain walk count ran past its bound")
  `FCBA_ASSERT_NEXT(a_count_hold, (state != ST_EVAL) && !rst, $stable(used_count), "used count changed outside evaluation")
  `FCBA_ASSERT_NEXT(a_result_hold, (state == ST_OUT) && !res_ready, (state == ST_OUT) && $stable(res), "pending result dropped or changed")

endmodule

`default_nettype wire

// ===== hdl/fat_chain_block_allocator_top.sv =====
// FAT chain block allocator: a linked free list over a file-allocation table.
// Slave beat: tuser = command (allocate, free chain, read link), tdata = block.
// Master beat: tuser = status (1 = no space), tdata = result block and the
// used-block count after the command. One result beat for every command beat.
// Limit register: cfg_wr_en/cfg_wr_data write the usable block limit; write
// only while the block is idle.
// After reset the link table is cleared to its start-up chain, one entry per
// cycle, and s_axis_tready stays low until every entry has been written.
// One command at a time. Allocate and read-link pass through the READ, EVAL
// and OUT states before the next accept; freeing a chain walks it in EVAL,
// bounded by the single table read port, which is walked one link per cycle.
// Out-of-range blocks and unknown commands go straight to OUT.
// The result sits in an output register; a stalled receiver holds it there,
// and one more command may complete into the sequencer before the block waits.
// Depends on fcba_pkg, fcba_seq, fcba_table, fcba_alu.
`timescale 1ns / 1ps
`default_nettype none

module fat_chain_block_allocator_top
  import fcba_pkg::*;
#(
  parameter int NUM_BLOCKS       = 4096,
  parameter int FIRST_DATA_BLOCK = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [15:0]  s_axis_tdata,   // [11:0] block, [15:12] zero
  input  wire logic [1:0]   s_axis_tuser,   // [1:0] command
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [23:0]  m_axis_tdata,   // [11:0] result_block, [23:12] used_blocks
  output logic      [0:0]   m_axis_tuser,   // [0] status
  input  wire logic         cfg_wr_en,
  input  wire logic [11:0]  cfg_wr_data     // usable_block_limit
);

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int CW = $clog2(NUM_BLOCKS + 2);
  localparam int W  = (CW > FIELD_W) ? CW : FIELD_W;

  logic          res_valid;
  logic          res_ready;
  fcba_result_t  res;
  logic          tbl_wr_en;
  logic [AW-1:0] tbl_wr_addr;
  logic [AW-1:0] tbl_wr_data;
  logic [AW-1:0] tbl_rd_addr;
  logic [AW-1:0] tbl_rd_data;
  logic [W-1:0]  alu_a;
  logic [W-1:0]  alu_b;
  logic          alu_sub;
  logic [W-1:0]  alu_sum;
  logic          alu_msb;
  fcba_result_t  out_res;

  fcba_seq #(
    .NUM_BLOCKS       (NUM_BLOCKS),
    .FIRST_DATA_BLOCK (FIRST_DATA_BLOCK)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_cmd      (s_axis_tuser),
    .in_blk      (s_axis_tdata[FIELD_W-1:0]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .tbl_wr_en   (tbl_wr_en),
    .tbl_wr_addr (tbl_wr_addr),
    .tbl_wr_data (tbl_wr_data),
    .tbl_rd_addr (tbl_rd_addr),
    .tbl_rd_data (tbl_rd_data),
    .alu_a       (alu_a),
    .alu_b       (alu_b),
    .alu_sub     (alu_sub),
    .alu_sum     (alu_sum),
    .alu_msb     (alu_msb)
  );

  fcba_table #(
    .DEPTH (NUM_BLOCKS),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  fcba_alu #(
    .W (W)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum),
    .msb (alu_msb)
  );

  // output register between sequencer and master side
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {out_res.used_blocks, out_res.result_block};
  assign m_axis_tuser = out_res.status;

endmodule

`default_nettype wire
